FILE: rtl/core/pfr_pkg.sv
`default_nettype none

package pfr_pkg;

   localparam int FRAME_COUNT = 64;
   localparam int FRAME_W     = $clog2(FRAME_COUNT);
   localparam int COUNT_W     = $clog2(FRAME_COUNT + 1);
   localparam int INDEX_W     = 10;
   localparam int PAGE_W      = 2 * INDEX_W;
   localparam int STAMP_W     = 32;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic KIND_FAULT  = 1'b0;
   localparam logic KIND_TOUCH  = 1'b1;
   localparam logic POLICY_FIFO = 1'b0;
   localparam logic POLICY_LRU  = 1'b1;

   // register index taken from paddr above the byte offset
   localparam logic [CSR_ADDR_W-3:0] REG_POLICY = '0;

   typedef struct packed {
      logic capture;
      logic take_free;
      logic take_fifo;
      logic scan_start;
      logic scan_issue;
      logic page_read;
      logic victim_load;
      logic touch_write;
      logic finish;
   } pfr_cmd_type;

   typedef struct packed {
      logic kind_touch;
      logic has_free;
      logic policy_lru;
      logic scan_last;
      logic out_free;
   } pfr_status_type;

endpackage

`default_nettype wire

FILE: rtl/core/page_frame_replacement_fifo_lru.sv
`default_nettype none

// Page frame replacement unit. Each req word is either a page fault (kind 0),
// carrying a 20-bit page number split into outer and inner indexes plus an
// access stamp, or a touch (kind 1), which restamps a resident frame and
// gives no rsp word. A fault returns one rsp word with the frame now holding
// the page: free frames go out in rising order from 0; once all FRAME_COUNT
// frames are in use a victim is picked by the policy register at address 0
// (bit 0: 0 FIFO with a wrapping oldest-frame pointer, 1 LRU by smallest
// stamp, lowest index on ties, stamps unsigned) and its old page number is
// reported for invalidation. One word is worked on at a time; an LRU eviction
// scans every frame's stamp, reading one stamp per cycle from the stamp
// memory's single read port. The result is loaded into an output register at
// the write-back and may wait there while the next word is accepted. Frame
// memories are not cleared; only frames already handed out are ever read.
// Write the policy only while the unit is idle.
module page_frame_replacement_fifo_lru (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request channel
   input  wire logic                            req_valid,
   output      logic                            req_stall,
   input  wire logic                            req_kind,
   input  wire logic [pfr_pkg::INDEX_W-1:0]     req_outer_index,
   input  wire logic [pfr_pkg::INDEX_W-1:0]     req_inner_index,
   input  wire logic [pfr_pkg::FRAME_W-1:0]     req_touched_frame,
   input  wire logic [pfr_pkg::STAMP_W-1:0]     req_access_stamp,
   // response channel
   output      logic                            rsp_valid,
   input  wire logic                            rsp_stall,
   output      logic [pfr_pkg::FRAME_W-1:0]     rsp_assigned_frame,
   output      logic                            rsp_eviction_done,
   output      logic [pfr_pkg::PAGE_W-1:0]      rsp_victim_page,
   // register port
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [pfr_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [pfr_pkg::CSR_DATA_W-1:0]  pwdata,
   output      logic [pfr_pkg::CSR_DATA_W-1:0]  prdata,
   output      logic                            pready
);

   import pfr_pkg::*;

   logic           policy_ff;
   logic           policy_in;
   logic           csr_hit;
   pfr_cmd_type    cmd;
   pfr_status_type status;

   // Decode the register index above the byte offset; unknown indexes read
   // as zero and drop writes.
   assign csr_hit = (paddr[CSR_ADDR_W-1:2] == REG_POLICY);
   assign pready  = 1'b1;

   always_comb begin
      policy_in = policy_ff;
      if (psel && penable && pwrite && pready && csr_hit) begin
         policy_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= POLICY_FIFO;
      end else begin
         policy_ff <= policy_in;
      end
   end

   assign prdata = csr_hit ? CSR_DATA_W'(policy_ff) : '0;

   // Sequencer: accept, pick a frame, scan or fetch the victim, write back.
   pfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Frame bookkeeping, stamp and page memories, result register.
   pfr_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .policy             (policy_ff),
      .req_kind           (req_kind),
      .req_outer_index    (req_outer_index),
      .req_inner_index    (req_inner_index),
      .req_touched_frame  (req_touched_frame),
      .req_access_stamp   (req_access_stamp),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_assigned_frame (rsp_assigned_frame),
      .rsp_eviction_done  (rsp_eviction_done),
      .rsp_victim_page    (rsp_victim_page)
   );

endmodule

`default_nettype wire

FILE: rtl/core/pfr_ram.sv
`default_nettype none

module pfr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/core/pfr_ctrl.sv
`default_nettype none

module pfr_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output      logic                    req_stall,
   input  wire pfr_pkg::pfr_status_type status,
   output      pfr_pkg::pfr_cmd_type    cmd
);

   import pfr_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_SCAN,
      ST_SCAN_END,
      ST_VICTIM,
      ST_VREAD,
      ST_WRITE
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (status.kind_touch) begin
               cmd.touch_write = 1'b1;
               state_in        = ST_IDLE;
            end else if (status.has_free) begin
               cmd.take_free = 1'b1;
               state_in      = ST_WRITE;
            end else if (status.policy_lru) begin
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN;
            end else begin
               cmd.take_fifo = 1'b1;
               state_in      = ST_VICTIM;
            end
         end
         ST_SCAN: begin
            cmd.scan_issue = 1'b1;
            if (status.scan_last) begin
               state_in = ST_SCAN_END;
            end
         end
         ST_SCAN_END: begin
            // last stamp compare lands this cycle
            state_in = ST_VICTIM;
         end
         ST_VICTIM: begin
            cmd.page_read = 1'b1;
            state_in      = ST_VREAD;
         end
         ST_VREAD: begin
            cmd.victim_load = 1'b1;
            state_in        = ST_WRITE;
         end
         ST_WRITE: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

FILE: rtl/core/pfr_dp.sv
`default_nettype none

module pfr_dp (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire pfr_pkg::pfr_cmd_type         cmd,
   output      pfr_pkg::pfr_status_type      status,
   input  wire logic                         policy,
   input  wire logic                         req_kind,
   input  wire logic [pfr_pkg::INDEX_W-1:0]  req_outer_index,
   input  wire logic [pfr_pkg::INDEX_W-1:0]  req_inner_index,
   input  wire logic [pfr_pkg::FRAME_W-1:0]  req_touched_frame,
   input  wire logic [pfr_pkg::STAMP_W-1:0]  req_access_stamp,
   output      logic                         rsp_valid,
   input  wire logic                         rsp_stall,
   output      logic [pfr_pkg::FRAME_W-1:0]  rsp_assigned_frame,
   output      logic                         rsp_eviction_done,
   output      logic [pfr_pkg::PAGE_W-1:0]   rsp_victim_page
);

   import pfr_pkg::*;

   logic                kind_ff,    kind_in;
   logic [PAGE_W-1:0]   page_ff,    page_in;
   logic [FRAME_W-1:0]  touched_ff, touched_in;
   logic [STAMP_W-1:0]  stamp_ff,   stamp_in;
   logic [COUNT_W-1:0]  used_ff,    used_in;
   logic [FRAME_W-1:0]  fifo_ptr_ff, fifo_ptr_in;
   logic [FRAME_W-1:0]  frame_ff,   frame_in;
   logic                evict_ff,   evict_in;
   logic [PAGE_W-1:0]   victim_ff,  victim_in;
   logic [STAMP_W-1:0]  best_ff,    best_in;
   logic [FRAME_W-1:0]  scan_cnt_ff, scan_cnt_in;
   logic                rd_pend_ff, rd_pend_in;
   logic [FRAME_W-1:0]  rd_idx_ff,  rd_idx_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [FRAME_W-1:0]  rsp_frame_ff, rsp_frame_in;
   logic                rsp_evict_ff, rsp_evict_in;
   logic [PAGE_W-1:0]   rsp_victim_ff, rsp_victim_in;

   logic [STAMP_W-1:0]  stamp_rdata;
   logic [PAGE_W-1:0]   page_rdata;
   logic                touch_ok;
   logic                stamp_wr_en;
   logic [FRAME_W-1:0]  stamp_wr_addr;
   logic                scan_last;

   localparam logic [FRAME_W-1:0] LAST_FRAME = FRAME_W'(FRAME_COUNT - 1);

   assign scan_last = (scan_cnt_ff == LAST_FRAME);
   assign touch_ok  = (COUNT_W'(touched_ff) < used_ff);

   always_comb begin
      kind_in       = kind_ff;
      page_in       = page_ff;
      touched_in    = touched_ff;
      stamp_in      = stamp_ff;
      used_in       = used_ff;
      fifo_ptr_in   = fifo_ptr_ff;
      frame_in      = frame_ff;
      evict_in      = evict_ff;
      victim_in     = victim_ff;
      best_in       = best_ff;
      scan_cnt_in   = scan_cnt_ff;
      rd_pend_in    = cmd.scan_issue;
      rd_idx_in     = scan_cnt_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_frame_in  = rsp_frame_ff;
      rsp_evict_in  = rsp_evict_ff;
      rsp_victim_in = rsp_victim_ff;

      if (cmd.capture) begin
         kind_in    = req_kind;
         page_in    = {req_outer_index, req_inner_index};
         touched_in = req_touched_frame;
         stamp_in   = req_access_stamp;
      end
      if (cmd.take_free) begin
         frame_in  = used_ff[FRAME_W-1:0];
         used_in   = used_ff + COUNT_W'(1);
         evict_in  = 1'b0;
         victim_in = '0;
      end
      if (cmd.take_fifo) begin
         frame_in    = fifo_ptr_ff;
         fifo_ptr_in = (fifo_ptr_ff == LAST_FRAME) ? '0 : fifo_ptr_ff + FRAME_W'(1);
         evict_in    = 1'b1;
      end
      if (cmd.scan_start) begin
         scan_cnt_in = '0;
         evict_in    = 1'b1;
      end
      if (cmd.scan_issue) begin
         scan_cnt_in = scan_last ? '0 : scan_cnt_ff + FRAME_W'(1);
      end
      // keep the first smallest stamp: strict less-than favors the lower index
      if (rd_pend_ff && ((rd_idx_ff == '0) || (stamp_rdata < best_ff))) begin
         best_in  = stamp_rdata;
         frame_in = rd_idx_ff;
      end
      if (cmd.victim_load) begin
         victim_in = page_rdata;
      end
      if (cmd.finish) begin
         rsp_valid_in  = 1'b1;
         rsp_frame_in  = frame_ff;
         rsp_evict_in  = evict_ff;
         rsp_victim_in = victim_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         fifo_ptr_ff  <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         fifo_ptr_ff  <= fifo_ptr_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff       <= kind_in;
      page_ff       <= page_in;
      touched_ff    <= touched_in;
      stamp_ff      <= stamp_in;
      frame_ff      <= frame_in;
      evict_ff      <= evict_in;
      victim_ff     <= victim_in;
      best_ff       <= best_in;
      scan_cnt_ff   <= scan_cnt_in;
      rd_idx_ff     <= rd_idx_in;
      rsp_frame_ff  <= rsp_frame_in;
      rsp_evict_ff  <= rsp_evict_in;
      rsp_victim_ff <= rsp_victim_in;
   end

   assign stamp_wr_en   = cmd.finish | (cmd.touch_write & touch_ok);
   assign stamp_wr_addr = cmd.touch_write ? touched_ff : frame_ff;

   pfr_ram #(
      .WIDTH (STAMP_W),
      .DEPTH (FRAME_COUNT)
   ) u_stamp_ram (
      .clock   (clock),
      .wr_en   (stamp_wr_en),
      .wr_addr (stamp_wr_addr),
      .wr_data (stamp_ff),
      .rd_en   (cmd.scan_issue),
      .rd_addr (scan_cnt_ff),
      .rd_data (stamp_rdata)
   );

   pfr_ram #(
      .WIDTH (PAGE_W),
      .DEPTH (FRAME_COUNT)
   ) u_page_ram (
      .clock   (clock),
      .wr_en   (cmd.finish),
      .wr_addr (frame_ff),
      .wr_data (page_ff),
      .rd_en   (cmd.page_read),
      .rd_addr (frame_ff),
      .rd_data (page_rdata)
   );

   always_comb begin
      status            = '0;
      status.kind_touch = (kind_ff == KIND_TOUCH);
      status.has_free   = (used_ff < COUNT_W'(FRAME_COUNT));
      status.policy_lru = (policy == POLICY_LRU);
      status.scan_last  = scan_last;
      status.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_assigned_frame = rsp_frame_ff;
   assign rsp_eviction_done  = rsp_evict_ff;
   assign rsp_victim_page    = rsp_victim_ff;

`ifndef SYNTHESIS
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= COUNT_W'(FRAME_COUNT))
      else $error("frame count beyond capacity");

   a_free_no_victim: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_evict_ff |-> rsp_victim_ff == '0)
      else $error("free-frame word carries a victim page");

   a_evict_only_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_evict_ff |-> used_ff == COUNT_W'(FRAME_COUNT))
      else $error("eviction reported while free frames remain");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !rsp_valid_ff || !rsp_stall)
      else $error("result register overwritten while stalled");

   a_free_path_full: assert property (@(posedge clock) disable iff (reset)
      cmd.take_free |=> used_ff != '0)
      else $error("free frame taken without count advance");
`endif

endmodule

`default_nettype wire
